@@ src/frif_pkg.sv @@
package frif_pkg;

	localparam int SECTOR_COUNT     = 256;
	localparam int BYTES_PER_SECTOR = 512;

	localparam int STORE_DEPTH = SECTOR_COUNT * BYTES_PER_SECTOR;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int OFF_W       = $clog2(BYTES_PER_SECTOR);
	localparam int ROW_W       = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
	localparam int LEN_W       = 10;
	localparam int CMP_W       = (OFF_W + 1 > LEN_W) ? OFF_W + 1 : LEN_W;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [LEN_W-1:0] TLEN_RESET   = LEN_W'(24);
	localparam logic [LEN_W-1:0] MSTART_RESET = LEN_W'(500);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [OFF_W-1:0]  off_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [CMP_W-1:0]  cmp_t;
	typedef row_t              row_lut_t [256];

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_TICK  = 2'd2,
		OP_RESET = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_CMD    = 3'd0,
		REG_SECTOR = 3'd1,
		REG_MOTOR  = 3'd2,
		REG_DATA   = 3'd3
	} reg_t;

	typedef enum logic {
		CFG_TLEN   = 1'b0,
		CFG_MSTART = 1'b1
	} cfg_t;

	localparam logic [7:0] CMD_CLEAR_ACK = 8'h01;
	localparam logic [7:0] CMD_SET_ACK   = 8'h20;
	localparam logic [7:0] CMD_READ      = 8'h40;
	localparam logic [7:0] CMD_NOP       = 8'h60;
	localparam logic [7:0] CMD_ACK       = 8'h80;
	localparam logic [7:0] CMD_WRITE     = 8'hA0;

	localparam logic [7:0] STAT_BASE      = 8'h08;
	localparam logic [7:0] STAT_MOTOR_ON  = 8'h40;
	localparam logic [7:0] STAT_MOTOR_OFF = 8'h80;
	localparam logic [7:0] STAT_NO_ACK    = 8'h01;
	localparam logic [7:0] STAT_READY     = 8'h02;
	localparam logic [7:0] STAT_BUSY      = 8'h80;
	localparam logic [7:0] UNUSED_READ    = 8'hFF;

	typedef struct packed {
		logic       wr;
		logic       rd;
		addr_t      addr;
		logic [7:0] wdata;
	} store_req_t;

	function automatic row_lut_t row_lut();
		row_lut_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = row_t'(i % SECTOR_COUNT);
		end
		return t;
	endfunction

	localparam row_lut_t ROW_LUT = row_lut();

endpackage

@@ src/frif_if.sv @@
interface frif_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [2:0] reg_index;
	logic [7:0] wdata;

	modport source (output valid, output op, output reg_index, output wdata, input ready);
	modport sink (input valid, input op, input reg_index, input wdata, output ready);
endinterface

interface frif_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

@@ src/frif_store.sv @@
module frif_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  frif_pkg::store_req_t req,
	output logic [7:0]           rdata,
	output logic                 ready
);

	logic [7:0]      mem [frif_pkg::STORE_DEPTH];
	logic            clr_busy_q;
	frif_pkg::addr_t clr_addr_q;
	logic [7:0]      rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == frif_pkg::addr_t'(frif_pkg::STORE_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= 8'h00;
		end else if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;
	assign ready = !clr_busy_q;

endmodule

@@ src/floppy_register_interface_unit.sv @@
// Channel | Direction | Handshake    | Payload
// cmd     | in        | valid/ready  | op, reg_index, wdata
// resp    | out       | valid/ready  | read_data
// apb     | in        | psel/penable | paddr, pwdata, prdata (pready tied high)
//
// One transfer is taken per cycle while resp is not stalled and the store is ready;
// its result passes through the input register and then the result register.
// Data reads take their byte from the store's registered read port, loaded with the result register.
// After reset the store is swept to zero, one byte a cycle, over all
// SECTOR_COUNT * BYTES_PER_SECTOR bytes (131072); cmd is not ready until then.
// A stalled resp holds its result while one more transfer waits in the input register.
module floppy_register_interface_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	frif_in_if.sink                       cmd,
	frif_out_if.source                    resp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [frif_pkg::PADDR_W-1:0]  paddr,
	input  logic [frif_pkg::PDATA_W-1:0]  pwdata,
	output logic [frif_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	logic [frif_pkg::LEN_W-1:0] tlen_q;
	logic [frif_pkg::LEN_W-1:0] mstart_q;

	logic [7:0]            last_cmd_q, last_cmd_nxt;
	logic [7:0]            sector_q, sector_nxt;
	frif_pkg::off_t        offset_q, offset_nxt;
	logic                  ack_q, ack_nxt;
	logic                  busy_q, busy_nxt;
	logic                  motor_on_q, motor_on_nxt;
	logic                  motor_wait_q, motor_wait_nxt;
	logic [9:0]            wait_cnt_q, wait_cnt_nxt;

	logic                  valid_s1_q;
	frif_pkg::op_t         op_s1;
	logic [2:0]            reg_s1;
	logic [7:0]            wdata_s1;

	logic                  valid_s2_q;
	logic [7:0]            rdata_s2;
	logic                  mem_sel_s2;

	logic                  out_free, s1_free, fire_s1, in_fire;
	logic                  store_ready;
	logic [7:0]            store_rdata;
	frif_pkg::store_req_t  store_req;
	logic [7:0]            rdata_nxt;
	logic                  mem_sel_nxt;

	logic [frif_pkg::OFF_W:0] offset_inc;
	frif_pkg::off_t           adv_offset;
	logic                     adv_ack;
	frif_pkg::addr_t          cur_addr;
	logic [10:0]              wait_inc;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q   <= frif_pkg::TLEN_RESET;
			mstart_q <= frif_pkg::MSTART_RESET;
		end else if (psel && penable && pwrite) begin
			if (frif_pkg::cfg_t'(paddr[2]) == frif_pkg::CFG_MSTART) begin
				mstart_q <= pwdata[frif_pkg::LEN_W-1:0];
			end else begin
				tlen_q <= pwdata[frif_pkg::LEN_W-1:0];
			end
		end
	end

	always_comb begin
		if (frif_pkg::cfg_t'(paddr[2]) == frif_pkg::CFG_MSTART) begin
			prdata = frif_pkg::PDATA_W'(mstart_q);
		end else begin
			prdata = frif_pkg::PDATA_W'(tlen_q);
		end
	end

	assign out_free = !valid_s2_q || resp.ready;
	assign s1_free  = !valid_s1_q || out_free;
	assign fire_s1  = valid_s1_q && out_free;
	assign cmd.ready = store_ready && s1_free;
	assign in_fire  = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1_q <= in_fire;
			end
			if (out_free) begin
				valid_s2_q <= fire_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= frif_pkg::op_t'(cmd.op);
			reg_s1   <= cmd.reg_index;
			wdata_s1 <= cmd.wdata;
		end
		if (fire_s1) begin
			rdata_s2   <= rdata_nxt;
			mem_sel_s2 <= mem_sel_nxt;
		end
	end

	assign offset_inc = {1'b0, offset_q} + 1'b1;
	assign adv_offset = (offset_inc == (frif_pkg::OFF_W + 1)'(frif_pkg::BYTES_PER_SECTOR))
		? '0 : offset_inc[frif_pkg::OFF_W-1:0];
	assign adv_ack = frif_pkg::cmp_t'(offset_inc) == frif_pkg::cmp_t'(tlen_q);
	assign cur_addr = frif_pkg::addr_t'(frif_pkg::ROW_LUT[sector_q])
		* frif_pkg::addr_t'(frif_pkg::BYTES_PER_SECTOR) + frif_pkg::addr_t'(offset_q);
	assign wait_inc = {1'b0, wait_cnt_q} + 1'b1;

	always_comb begin
		last_cmd_nxt   = last_cmd_q;
		sector_nxt     = sector_q;
		offset_nxt     = offset_q;
		ack_nxt        = ack_q;
		busy_nxt       = busy_q;
		motor_on_nxt   = motor_on_q;
		motor_wait_nxt = motor_wait_q;
		wait_cnt_nxt   = wait_cnt_q;
		store_req      = '0;
		store_req.addr = cur_addr;
		store_req.wdata = wdata_s1;
		rdata_nxt      = 8'h00;
		mem_sel_nxt    = 1'b0;
		if (fire_s1) begin
			unique case (op_s1)
				frif_pkg::OP_WRITE: begin
					unique case (reg_s1)
						frif_pkg::REG_CMD: begin
							last_cmd_nxt = wdata_s1;
							unique case (wdata_s1)
								frif_pkg::CMD_CLEAR_ACK: begin
									ack_nxt    = 1'b0;
									offset_nxt = '0;
								end
								frif_pkg::CMD_SET_ACK: begin
									ack_nxt    = 1'b1;
									offset_nxt = '0;
								end
								frif_pkg::CMD_READ: begin
									busy_nxt = 1'b1;
								end
								frif_pkg::CMD_NOP: begin
								end
								frif_pkg::CMD_ACK: begin
									ack_nxt = 1'b1;
								end
								frif_pkg::CMD_WRITE: begin
									offset_nxt = '0;
									busy_nxt   = 1'b1;
									ack_nxt    = 1'b0;
								end
								default: begin
									ack_nxt = 1'b0;
								end
							endcase
						end
						frif_pkg::REG_SECTOR: begin
							sector_nxt = wdata_s1;
							offset_nxt = '0;
						end
						frif_pkg::REG_MOTOR: begin
							if (wdata_s1[7]) begin
								if (!motor_on_q) begin
									motor_wait_nxt = 1'b1;
									wait_cnt_nxt   = '0;
									busy_nxt       = 1'b1;
								end
							end else begin
								motor_on_nxt   = 1'b0;
								motor_wait_nxt = 1'b0;
								wait_cnt_nxt   = '0;
							end
						end
						frif_pkg::REG_DATA: begin
							if (last_cmd_q == frif_pkg::CMD_CLEAR_ACK) begin
								ack_nxt = 1'b1;
							end else if (last_cmd_q == frif_pkg::CMD_WRITE) begin
								store_req.wr = 1'b1;
								offset_nxt   = adv_offset;
								if (adv_ack) begin
									ack_nxt = 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end
				frif_pkg::OP_READ: begin
					unique case (reg_s1)
						frif_pkg::REG_CMD: begin
							rdata_nxt = frif_pkg::STAT_BASE | (motor_on_q
								? frif_pkg::STAT_MOTOR_ON : frif_pkg::STAT_MOTOR_OFF);
						end
						frif_pkg::REG_SECTOR: begin
							rdata_nxt = sector_q;
						end
						frif_pkg::REG_MOTOR: begin
							rdata_nxt = (ack_q ? 8'h00 : frif_pkg::STAT_NO_ACK)
								| frif_pkg::STAT_READY | (busy_q ? frif_pkg::STAT_BUSY : 8'h00);
						end
						frif_pkg::REG_DATA: begin
							if (last_cmd_q == frif_pkg::CMD_READ) begin
								store_req.rd = 1'b1;
								mem_sel_nxt  = 1'b1;
								offset_nxt   = adv_offset;
								if (adv_ack) begin
									ack_nxt = 1'b1;
								end
							end
						end
						default: begin
							rdata_nxt = frif_pkg::UNUSED_READ;
						end
					endcase
				end
				frif_pkg::OP_TICK: begin
					if (motor_wait_q) begin
						if (wait_inc > {1'b0, mstart_q}) begin
							motor_on_nxt   = 1'b1;
							motor_wait_nxt = 1'b0;
							wait_cnt_nxt   = '0;
							busy_nxt       = 1'b0;
						end else begin
							wait_cnt_nxt = wait_inc[9:0];
						end
					end
				end
				frif_pkg::OP_RESET: begin
					if (!wdata_s1[0]) begin
						busy_nxt       = 1'b0;
						motor_on_nxt   = 1'b0;
						motor_wait_nxt = 1'b0;
						sector_nxt     = 8'h00;
						wait_cnt_nxt   = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q   <= 8'h00;
			sector_q     <= 8'h00;
			offset_q     <= '0;
			ack_q        <= 1'b0;
			busy_q       <= 1'b0;
			motor_on_q   <= 1'b0;
			motor_wait_q <= 1'b0;
			wait_cnt_q   <= '0;
		end else begin
			last_cmd_q   <= last_cmd_nxt;
			sector_q     <= sector_nxt;
			offset_q     <= offset_nxt;
			ack_q        <= ack_nxt;
			busy_q       <= busy_nxt;
			motor_on_q   <= motor_on_nxt;
			motor_wait_q <= motor_wait_nxt;
			wait_cnt_q   <= wait_cnt_nxt;
		end
	end

	frif_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rdata  (store_rdata),
		.ready  (store_ready)
	);

	assign resp.valid     = valid_s2_q;
	assign resp.read_data = mem_sel_s2 ? store_rdata : rdata_s2;

endmodule
